// ===== hdl/msobj_pkg.sv =====
// Shared types, codes and entry tables for the metasprite expander.
// No dependencies; every module of the block imports this package.
package msobj_pkg;

	// Frame size codes carried by a draw request.
	typedef enum logic [2:0] {
		FS_8X8   = 3'd0,
		FS_8X16  = 3'd1,
		FS_16X16 = 3'd2,
		FS_24X32 = 3'd3,
		FS_32X32 = 3'd4
	} ms_size_t;

	// Attribute bit positions for the flips.
	localparam int unsigned ATTR_HFLIP = 5;
	localparam int unsigned ATTR_VFLIP = 6;

	// Queue depth between the front and the back part.
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// One classified request as it travels through the queue.
	typedef struct packed {
		ms_size_t    size;
		logic [7:0]  base_tile;
		logic [7:0]  pos_x;
		logic [7:0]  pos_y;
		logic [7:0]  attr;
		logic [2:0]  last_idx;
	} ms_item_t;

	// Offsets of one object entry relative to the request.
	typedef struct packed {
		logic [3:0] tile_off;
		logic [5:0] x_off;
		logic [5:0] y_off;
	} ms_entry_t;

	// Index of the final entry for a known frame size.
	function automatic logic [2:0] ms_last_idx(input ms_size_t size);
		logic [2:0] r;
		case (size)
			FS_8X8, FS_8X16: r = 3'd0;
			FS_16X16:        r = 3'd1;
			FS_24X32:        r = 3'd5;
			FS_32X32:        r = 3'd7;
			default:         r = 3'd0;
		endcase
		return r;
	endfunction

	// Codes above the largest frame size produce no entries.
	function automatic logic ms_size_known(input logic [2:0] code);
		return (code <= 3'(FS_32X32));
	endfunction

	// Tile, x and y offsets of entry idx, with the flips applied.
	function automatic ms_entry_t ms_entry(input ms_size_t size, input logic [2:0] idx,
			input logic hflip, input logic vflip);
		ms_entry_t  e;
		logic [5:0] row0;
		logic [5:0] row1;
		row0 = vflip ? 6'd32 : 6'd16;
		row1 = vflip ? 6'd16 : 6'd32;
		e.tile_off = 4'd0;
		e.x_off    = 6'd8;
		e.y_off    = 6'd16;
		case (size)
			FS_8X8, FS_8X16: begin
				e.tile_off = 4'd0;
				e.x_off    = 6'd8;
				e.y_off    = 6'd16;
			end
			FS_16X16: begin
				e.tile_off = idx[0] ? 4'd2 : 4'd0;
				e.x_off    = (idx[0] ^ hflip) ? 6'd16 : 6'd8;
				e.y_off    = 6'd16;
			end
			FS_24X32: begin
				e.tile_off = {idx, 1'b0};
				case (idx)
					3'd0, 3'd2: e.x_off = hflip ? 6'd24 : 6'd8;
					3'd1, 3'd3: e.x_off = 6'd16;
					default:    e.x_off = hflip ? 6'd8 : 6'd24;
				endcase
				case (idx)
					3'd0, 3'd1, 3'd4: e.y_off = row0;
					default:          e.y_off = row1;
				endcase
			end
			FS_32X32: begin
				case (idx)
					3'd0:    e.tile_off = 4'd2;
					3'd1:    e.tile_off = 4'd6;
					3'd2:    e.tile_off = 4'd8;
					3'd3:    e.tile_off = 4'd12;
					3'd4:    e.tile_off = 4'd0;
					3'd5:    e.tile_off = 4'd4;
					3'd6:    e.tile_off = 4'd10;
					default: e.tile_off = 4'd14;
				endcase
				case (idx[2:1])
					2'd0:    e.x_off = hflip ? 6'd24 : 6'd16;
					2'd1:    e.x_off = hflip ? 6'd16 : 6'd24;
					2'd2:    e.x_off = hflip ? 6'd32 : 6'd8;
					default: e.x_off = hflip ? 6'd8 : 6'd32;
				endcase
				e.y_off = idx[0] ? row1 : row0;
			end
			default: begin
				e.tile_off = 4'd0;
				e.x_off    = 6'd8;
				e.y_off    = 6'd16;
			end
		endcase
		return e;
	endfunction

endpackage

// ===== hdl/msobj_front.sv =====
// Front part: takes draw requests, drops unused size codes, and holds
// one classified request until the queue has room. Uses msobj_pkg.
module msobj_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         frame_size,
	input  logic [7:0]         base_tile,
	input  logic [7:0]         pos_x,
	input  logic [7:0]         pos_y,
	input  logic [7:0]         attr_flags,
	output logic               push,
	output msobj_pkg::ms_item_t push_item,
	input  logic               q_full
);
	import msobj_pkg::*;

	logic     valid_q;
	ms_item_t item_q;
	logic     take;
	logic     known;

	// The held request leaves when the queue accepts it.
	assign push      = valid_q && !q_full;
	assign push_item = item_q;
	assign in_stall  = valid_q && q_full;
	assign take      = in_valid && !in_stall;
	assign known     = ms_size_known(frame_size);

	// Classification register; requests without entries are not kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= take && known;
		end
	end

	// Request payload with its precomputed final entry index.
	always_ff @(posedge clk) begin
		if (take && known) begin
			item_q.size      <= ms_size_t'(frame_size);
			item_q.base_tile <= base_tile;
			item_q.pos_x     <= pos_x;
			item_q.pos_y     <= pos_y;
			item_q.attr      <= attr_flags;
			item_q.last_idx  <= ms_last_idx(ms_size_t'(frame_size));
		end
	end

	// A held request always has a size with entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (item_q.size == FS_8X8 || item_q.size == FS_8X16 ||
			item_q.size == FS_16X16 || item_q.size == FS_24X32 ||
			item_q.size == FS_32X32))
		else $error("front holds a request with an unused size code");

	// A blocked request stays in place.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && q_full) |=> (valid_q && $stable(item_q)))
		else $error("front lost a blocked request");
endmodule

// ===== hdl/msobj_queue.sv =====
// Short request queue between the front and the back part.
// Register based, head readable in the cycle it is valid. Uses msobj_pkg.
module msobj_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  msobj_pkg::ms_item_t push_item,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output msobj_pkg::ms_item_t head_item
);
	import msobj_pkg::*;

	ms_item_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = slot_q[rd_ptr_q];

	// Pointer and fill count updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Slot storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// The fill count never passes the depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue overflow");

	// Nothing is taken from an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue pop while empty");
endmodule

// ===== hdl/msobj_back.sv =====
// Back part: walks the entries of the request at the queue head, one
// entry per cycle while out_stall allows, into the output register. Uses msobj_pkg.
module msobj_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  msobj_pkg::ms_item_t head_item,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          obj_y,
	output logic [7:0]          obj_x,
	output logic [7:0]          obj_tile,
	output logic [7:0]          obj_attr,
	output logic                last_entry
);
	import msobj_pkg::*;

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic       out_free;
	logic       go;
	logic       is_last;
	ms_entry_t  ent;

	// A new entry enters the output register when it is free or draining.
	assign out_free = !out_valid_q || !out_stall;
	assign go       = head_valid && out_free;
	assign is_last  = (idx_q == head_item.last_idx);
	assign pop      = go && is_last;
	assign ent      = ms_entry(head_item.size, idx_q,
		head_item.attr[ATTR_HFLIP], head_item.attr[ATTR_VFLIP]);
	assign out_valid = out_valid_q;

	// Entry counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
			end
			if (out_free) begin
				out_valid_q <= go;
			end
		end
	end

	// Output payload; all sums wrap at eight bits.
	always_ff @(posedge clk) begin
		if (go) begin
			obj_y      <= head_item.pos_y + {2'b00, ent.y_off};
			obj_x      <= head_item.pos_x + {2'b00, ent.x_off};
			obj_tile   <= head_item.base_tile + {4'b0000, ent.tile_off};
			obj_attr   <= head_item.attr;
			last_entry <= is_last;
		end
	end

	// The entry counter stays within the current request.
	assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (idx_q <= head_item.last_idx))
		else $error("entry index beyond the request");

	// Retiring a request puts its final entry on the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (out_valid && last_entry))
		else $error("request retired without its final entry");

	// The counter restarts after each request.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (idx_q == 3'd0))
		else $error("entry index not cleared after a request");
endmodule

// ===== hdl/metasprite_to_object_entries.sv =====
// A request passes the front register and the queue before its first entry reaches the output register.
// The walker emits one object entry per cycle while out_stall is low; a request holds it until
// all of its entries (1, 2, 6 or 8) are out, while unused size codes never reach it.
// A two-deep request queue lets the input keep moving while entries drain.
// Reset (arst_n low, asynchronous) empties the front register, queue and output.
// Top level of the metasprite expander; uses msobj_pkg and its three parts.
module metasprite_to_object_entries (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] frame_size,
	input  logic [7:0] base_tile,
	input  logic [7:0] pos_x,
	input  logic [7:0] pos_y,
	input  logic [7:0] attr_flags,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] obj_y,
	output logic [7:0] obj_x,
	output logic [7:0] obj_tile,
	output logic [7:0] obj_attr,
	output logic       last_entry
);
	import msobj_pkg::*;

	logic     push;
	logic     q_full;
	logic     pop;
	logic     head_valid;
	ms_item_t push_item;
	ms_item_t head_item;

	// Request intake and classification.
	msobj_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.frame_size (frame_size),
		.base_tile  (base_tile),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.attr_flags (attr_flags),
		.push       (push),
		.push_item  (push_item),
		.q_full     (q_full)
	);

	// Decoupling queue.
	msobj_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	// Entry walker and output register.
	msobj_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.obj_y      (obj_y),
		.obj_x      (obj_x),
		.obj_tile   (obj_tile),
		.obj_attr   (obj_attr),
		.last_entry (last_entry)
	);
endmodule

// ===== tb/metasprite_to_object_entries_test.sv =====
// Self-checking testbench for the metasprite expander: directed and random draw requests.
// Expected object entries come from a local model; depends on msobj_pkg and the top level.
`timescale 1ns / 1ps

module metasprite_to_object_entries_test;
	import msobj_pkg::*;

	// Size codes above the largest frame size, which yield no entries.
	localparam logic [2:0] FIRST_UNUSED_SIZE = 3'd5;
	localparam logic [2:0] LAST_UNUSED_SIZE  = 3'd7;
	localparam int unsigned RANDOM_REQUESTS  = 220;
	localparam int unsigned DRAIN_LIMIT      = 20000;

	// One expected object entry.
	typedef struct packed {
		logic [7:0] y;
		logic [7:0] x;
		logic [7:0] tile;
		logic [7:0] attr;
		logic       last;
	} obj_entry_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [2:0] frame_size = '0;
	logic [7:0] base_tile = '0;
	logic [7:0] pos_x = '0;
	logic [7:0] pos_y = '0;
	logic [7:0] attr_flags = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] obj_y;
	logic [7:0] obj_x;
	logic [7:0] obj_tile;
	logic [7:0] obj_attr;
	logic       last_entry;

	obj_entry_t expected_entries[$];
	obj_entry_t head_entry;
	int unsigned error_count = 0;
	int unsigned requests_sent = 0;
	int unsigned unused_requests = 0;
	int unsigned entries_checked = 0;
	int unsigned burst_left = 0;
	int unsigned stall_mode = 0;
	int unsigned stall_cycle = 0;
	int unsigned stall_hold = 0;

	metasprite_to_object_entries dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.frame_size (frame_size),
		.base_tile  (base_tile),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.attr_flags (attr_flags),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.obj_y      (obj_y),
		.obj_x      (obj_x),
		.obj_tile   (obj_tile),
		.obj_attr   (obj_attr),
		.last_entry (last_entry)
	);

	// Free-running clock with a 2 ns period.
	always #1 clk = ~clk;

	// Run limit, far above the slowest legal run.
	initial begin
		#400000;
		$display("FAIL");
		$finish;
	end

	// Queue one expected entry; all sums wrap at eight bits.
	function automatic void add_entry(input logic [7:0] tile, input logic [7:0] x,
			input logic [7:0] y, input logic [7:0] attr);
		obj_entry_t e;
		e.y    = y;
		e.x    = x;
		e.tile = tile;
		e.attr = attr;
		e.last = 1'b0;
		expected_entries.push_back(e);
	endfunction

	// Expand one accepted draw request into the entries it should produce.
	function automatic void expand_request(input logic [2:0] size, input logic [7:0] t,
			input logic [7:0] x, input logic [7:0] y, input logic [7:0] a);
		int unsigned before_count;
		logic [7:0]  vs;
		logic [7:0]  hs;
		logic [7:0]  row0;
		logic [7:0]  row1;
		before_count = expected_entries.size();
		vs   = a[ATTR_VFLIP] ? 8'd16 : 8'd0;
		row0 = y + 8'd16 + vs;
		row1 = y + 8'd32 - vs;
		case (size)
			FS_8X8, FS_8X16: begin
				add_entry(t, x + 8'd8, y + 8'd16, a);
			end
			FS_16X16: begin
				// One row only, so vertical flip has no effect.
				hs = a[ATTR_HFLIP] ? 8'd8 : 8'd0;
				add_entry(t, x + 8'd8 + hs, y + 8'd16, a);
				add_entry(t + 8'd2, x + 8'd16 - hs, y + 8'd16, a);
			end
			FS_24X32: begin
				hs = a[ATTR_HFLIP] ? 8'd16 : 8'd0;
				add_entry(t, x + 8'd8 + hs, row0, a);
				add_entry(t + 8'd2, x + 8'd16, row0, a);
				add_entry(t + 8'd4, x + 8'd8 + hs, row1, a);
				add_entry(t + 8'd6, x + 8'd16, row1, a);
				add_entry(t + 8'd8, x + 8'd24 - hs, row0, a);
				add_entry(t + 8'd10, x + 8'd24 - hs, row1, a);
			end
			FS_32X32: begin
				// Inner columns first, then the outer ones.
				hs = a[ATTR_HFLIP] ? 8'd8 : 8'd0;
				add_entry(t + 8'd2, x + 8'd16 + hs, row0, a);
				add_entry(t + 8'd6, x + 8'd16 + hs, row1, a);
				add_entry(t + 8'd8, x + 8'd24 - hs, row0, a);
				add_entry(t + 8'd12, x + 8'd24 - hs, row1, a);
				hs = a[ATTR_HFLIP] ? 8'd24 : 8'd0;
				add_entry(t, x + 8'd8 + hs, row0, a);
				add_entry(t + 8'd4, x + 8'd8 + hs, row1, a);
				add_entry(t + 8'd10, x + 8'd32 - hs, row0, a);
				add_entry(t + 8'd14, x + 8'd32 - hs, row1, a);
			end
			default: begin
			end
		endcase
		if (expected_entries.size() > before_count)
			expected_entries[expected_entries.size() - 1].last = 1'b1;
	endfunction

	// Sender pacing: bursts of random length separated by random gaps.
	task automatic pace_sender();
		int unsigned gap;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 4);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Present one request, wait for its transfer, then record its entries.
	task automatic send_request(input logic [2:0] size, input logic [7:0] tile,
			input logic [7:0] x, input logic [7:0] y, input logic [7:0] attr);
		in_valid   <= 1'b1;
		frame_size <= size;
		base_tile  <= tile;
		pos_x      <= x;
		pos_y      <= y;
		attr_flags <= attr;
		do @(posedge clk); while (in_stall);
		expand_request(size, tile, x, y, attr);
		requests_sent++;
		if (size > 3'(FS_32X32))
			unused_requests++;
		pace_sender();
	endtask

	// Hold the input idle until every expected entry has arrived.
	task automatic wait_for_drain();
		int unsigned cycles;
		cycles = 0;
		in_valid <= 1'b0;
		while (expected_entries.size() > 0 && cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		if (expected_entries.size() > 0) begin
			$error("%0d object entries never arrived", expected_entries.size());
			error_count++;
			expected_entries.delete();
		end
	endtask

	// Receiver stall pattern: the mode is redrawn at random from a free-running cycle counter.
	always @(posedge clk) begin
		stall_cycle <= stall_cycle + 1;
		if (stall_cycle % 64 == 0)
			stall_mode <= $urandom_range(0, 4);
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
			out_stall  <= 1'b1;
		end else begin
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 9) < 6);
				3: out_stall <= (stall_cycle % 3 == 0);
				default: begin
					out_stall <= 1'b0;
					if ($urandom_range(0, 15) == 0)
						stall_hold <= $urandom_range(5, 20);
				end
			endcase
		end
	end

	// Compare each transferred entry with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_entries.size() == 0) begin
				$error("Unexpected object entry: y %0d x %0d tile %0d attr %0h last %0d",
					obj_y, obj_x, obj_tile, obj_attr, last_entry);
				error_count++;
			end else begin
				head_entry = expected_entries.pop_front();
				entries_checked++;
				if (obj_y !== head_entry.y) begin
					$error("obj_y mismatch: expected %0d, actual %0d", head_entry.y, obj_y);
					error_count++;
				end
				if (obj_x !== head_entry.x) begin
					$error("obj_x mismatch: expected %0d, actual %0d", head_entry.x, obj_x);
					error_count++;
				end
				if (obj_tile !== head_entry.tile) begin
					$error("obj_tile mismatch: expected %0d, actual %0d",
						head_entry.tile, obj_tile);
					error_count++;
				end
				if (obj_attr !== head_entry.attr) begin
					$error("obj_attr mismatch: expected %0h, actual %0h",
						head_entry.attr, obj_attr);
					error_count++;
				end
				if (last_entry !== head_entry.last) begin
					$error("last_entry mismatch: expected %0d, actual %0d",
						head_entry.last, last_entry);
					error_count++;
				end
			end
		end
	end

	// Single-entry frames, with the vertical flip that they ignore.
	task automatic test_single_entry_frames();
		send_request(FS_8X8, 8'h00, 8'h00, 8'h00, 8'h00);
		send_request(FS_8X16, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_request(FS_8X8, 8'h80, 8'hF8, 8'hF0, 8'h40);
	endtask

	// Two-entry frames: horizontal flip swaps the columns; wrap of tile and x.
	task automatic test_two_entry_frames();
		send_request(FS_16X16, 8'hFF, 8'hFA, 8'h00, 8'h20);
		send_request(FS_16X16, 8'h01, 8'h00, 8'hF0, 8'h60);
		send_request(FS_16X16, 8'h07, 8'h07, 8'h07, 8'h00);
	endtask

	// Six-entry frames under every flip combination, near the wrap point.
	task automatic test_24x32_flips();
		for (int f = 0; f < 4; f++)
			send_request(FS_24X32, 8'd250, 8'd240, 8'd230, (8'(f) << ATTR_HFLIP) | 8'h03);
	endtask

	// Eight-entry frames under every flip combination.
	task automatic test_32x32_flips();
		for (int f = 0; f < 4; f++)
			send_request(FS_32X32, 8'd244, 8'd250, 8'd224, (8'(f) << ATTR_HFLIP) | 8'h9C);
	endtask

	// Unused size codes must be taken and produce nothing.
	task automatic test_unused_sizes();
		for (int c = FIRST_UNUSED_SIZE; c <= LAST_UNUSED_SIZE; c++)
			send_request(3'(c), 8'h55, 8'hAA, 8'h33, 8'hFF);
		send_request(FS_8X8, 8'h12, 8'h34, 8'h56, 8'h9F);
	endtask

	// Input pauses until the output side is completely drained.
	task automatic test_pause_until_drained();
		send_request(FS_32X32, 8'h10, 8'h20, 8'h30, 8'h00);
		send_request(FS_24X32, 8'h11, 8'h21, 8'h31, 8'h60);
		wait_for_drain();
		send_request(FS_32X32, 8'hF0, 8'hE0, 8'hD0, 8'h20);
	endtask

	// Random requests, mostly multi-entry frames with full-range fields.
	task automatic test_random_requests();
		int unsigned pick;
		logic [2:0]  size;
		for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 10)
				size = FS_8X8;
			else if (pick < 20)
				size = FS_8X16;
			else if (pick < 40)
				size = FS_16X16;
			else if (pick < 65)
				size = FS_24X32;
			else if (pick < 90)
				size = FS_32X32;
			else
				size = 3'($urandom_range(FIRST_UNUSED_SIZE, LAST_UNUSED_SIZE));
			send_request(size, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	// Reset, run each test in turn, then drain and report.
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_entry_frames();
		test_two_entry_frames();
		test_24x32_flips();
		test_32x32_flips();
		test_unused_sizes();
		test_pause_until_drained();
		test_random_requests();
		wait_for_drain();
		repeat (10) @(posedge clk);
		$display("Sent %0d draw requests (%0d with unused size codes), all flip combinations,",
			requests_sent, unused_requests);
		$display("and checked %0d object entries under random input gaps and output stalls.",
			entries_checked);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/msobj_pkg.sv
hdl/msobj_front.sv
hdl/msobj_queue.sv
hdl/msobj_back.sv
hdl/metasprite_to_object_entries.sv
tb/metasprite_to_object_entries_test.sv
